>>> sv/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// Types and constants of the TFTP packet parser: channel payloads, the record
// passed from the classifier to the status stage, field tags, opcodes, status.
// ----------------------------------------------------------------------------
package tpp_pkg;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       is_last;
    } tpp_in_t;

    typedef struct packed {
        logic [7:0]  echo_byte;
        logic [3:0]  field_tag;
        logic        packet_done;
        logic [1:0]  parse_status;
        logic [15:0] opcode_value;
        logic [15:0] number_value;
    } tpp_out_t;

    // classified byte and its position, with the opcode, number and terminator count as they stand after this byte
    typedef struct packed {
        logic [7:0]  pkt_byte;
        logic [3:0]  tag;
        logic        last;
        logic [2:0]  pos;
        logic [15:0] opcode;
        logic [15:0] number;
        logic [1:0]  terms;
    } tpp_work_t;

    localparam logic [3:0] TAG_OPCODE   = 4'd0;
    localparam logic [3:0] TAG_FILENAME = 4'd1;
    localparam logic [3:0] TAG_NAME_END = 4'd2;
    localparam logic [3:0] TAG_MODE     = 4'd3;
    localparam logic [3:0] TAG_MODE_END = 4'd4;
    localparam logic [3:0] TAG_BLOCK    = 4'd5;
    localparam logic [3:0] TAG_PAYLOAD  = 4'd6;
    localparam logic [3:0] TAG_CODE     = 4'd7;
    localparam logic [3:0] TAG_MESSAGE  = 4'd8;
    localparam logic [3:0] TAG_MSG_END  = 4'd9;
    localparam logic [3:0] TAG_TRAIL    = 4'd10;

    localparam logic [15:0] OP_RRQ   = 16'd1;
    localparam logic [15:0] OP_WRQ   = 16'd2;
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_NOTERM  = 2'd2;
    localparam logic [1:0] ST_UNSUPP  = 2'd3;

    localparam logic [2:0] POS_OP_HI  = 3'd0;
    localparam logic [2:0] POS_OP_LO  = 3'd1;
    localparam logic [2:0] POS_NUM_HI = 3'd2;
    localparam logic [2:0] POS_NUM_LO = 3'd3;
    localparam logic [2:0] POS_MAX    = 3'd7;

    localparam logic [1:0] TERMS_NONE = 2'd0;
    localparam logic [1:0] TERMS_ONE  = 2'd1;
    localparam logic [1:0] TERMS_TWO  = 2'd2;

endpackage

>>> sv/tpp_front.sv
// ----------------------------------------------------------------------------
// tpp_front
// Classifier: tracks byte position, opcode, number and string terminators
// and tags each accepted byte with its field.
// ----------------------------------------------------------------------------
module tpp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  tpp_pkg::tpp_in_t    pkt,
    output tpp_pkg::tpp_work_t  work
);
    import tpp_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [15:0] op_reg, op_next;
    logic [15:0] num_reg, num_next;
    logic [1:0]  terms_reg, terms_next;

    logic [7:0]  b;
    logic [3:0]  tag;
    logic        zero_byte;
    logic        early;

    always_comb
    begin
        b         = pkt.packet_byte;
        zero_byte = (b == 8'h00);
        early     = (pos_reg <= POS_NUM_LO);
        op_next    = op_reg;
        num_next   = num_reg;
        terms_next = terms_reg;
        tag        = TAG_TRAIL;

        if (pos_reg == POS_OP_HI)
        begin
            op_next = {b, 8'h00};
            tag     = TAG_OPCODE;
        end
        else if (pos_reg == POS_OP_LO)
        begin
            op_next = {op_reg[15:8], b};
            tag     = TAG_OPCODE;
        end
        else
        begin
            if (pos_reg == POS_NUM_HI)
            begin
                num_next = {b, 8'h00};
            end
            else if (pos_reg == POS_NUM_LO)
            begin
                num_next = {num_reg[15:8], b};
            end

            if (op_reg == OP_RRQ || op_reg == OP_WRQ)
            begin
                if (terms_reg == TERMS_NONE)
                begin
                    tag = zero_byte ? TAG_NAME_END : TAG_FILENAME;
                    if (zero_byte)
                    begin
                        terms_next = TERMS_ONE;
                    end
                end
                else if (terms_reg == TERMS_ONE)
                begin
                    tag = zero_byte ? TAG_MODE_END : TAG_MODE;
                    if (zero_byte)
                    begin
                        terms_next = TERMS_TWO;
                    end
                end
            end
            else if (op_reg == OP_DATA)
            begin
                tag = early ? TAG_BLOCK : TAG_PAYLOAD;
            end
            else if (op_reg == OP_ACK)
            begin
                tag = early ? TAG_BLOCK : TAG_TRAIL;
            end
            else if (op_reg == OP_ERROR)
            begin
                if (early)
                begin
                    tag = TAG_CODE;
                end
                else if (terms_reg == TERMS_NONE)
                begin
                    tag = zero_byte ? TAG_MSG_END : TAG_MESSAGE;
                    if (zero_byte)
                    begin
                        terms_next = TERMS_ONE;
                    end
                end
            end
        end

        // saturating position, cleared after the final byte
        if (pkt.is_last)
        begin
            pos_next = POS_OP_HI;
        end
        else if (pos_reg == POS_MAX)
        begin
            pos_next = POS_MAX;
        end
        else
        begin
            pos_next = pos_reg + 3'd1;
        end

        work.pkt_byte = b;
        work.tag      = tag;
        work.last     = pkt.is_last;
        work.pos      = pos_reg;
        work.opcode   = op_next;
        work.number   = num_next;
        work.terms    = terms_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_OP_HI;
            op_reg    <= '0;
            num_reg   <= '0;
            terms_reg <= TERMS_NONE;
        end
        else if (take)
        begin
            pos_reg <= pos_next;
            if (pkt.is_last)
            begin
                op_reg    <= '0;
                num_reg   <= '0;
                terms_reg <= TERMS_NONE;
            end
            else
            begin
                op_reg    <= op_next;
                num_reg   <= num_next;
                terms_reg <= terms_next;
            end
        end
    end

endmodule

>>> sv/tpp_queue.sv
// ----------------------------------------------------------------------------
// tpp_queue
// Short FIFO of classified bytes between classifier and status stage.
// ----------------------------------------------------------------------------
module tpp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tpp_pkg::tpp_work_t  push_data,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output tpp_pkg::tpp_work_t  head
);
    import tpp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tpp_work_t       mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/tpp_back.sv
// ----------------------------------------------------------------------------
// tpp_back
// Status stage: works out status, opcode and number on the final byte and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module tpp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  tpp_pkg::tpp_work_t  head,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output tpp_pkg::tpp_out_t   res
);
    import tpp_pkg::*;

    logic      res_valid_reg, res_valid_next;
    tpp_out_t  res_reg, res_next;
    logic      load;
    logic      is_req, is_num_op, unsupp;
    logic [2:0] min_last;
    logic [1:0] status;

    assign load = !res_valid_reg || res_ready;
    assign pop  = head_valid && load;

    always_comb
    begin
        is_req    = (head.opcode == OP_RRQ) || (head.opcode == OP_WRQ);
        is_num_op = (head.opcode == OP_DATA) || (head.opcode == OP_ACK)
                    || (head.opcode == OP_ERROR);
        unsupp    = (head.opcode == 16'd0) || (head.opcode > OP_ERROR);

        // lowest final-byte position at which the packet is long enough
        if (is_req)
        begin
            min_last = 3'd5;
        end
        else if (head.opcode == OP_ERROR)
        begin
            min_last = 3'd4;
        end
        else
        begin
            min_last = 3'd3;
        end

        priority if (head.pos == POS_OP_HI)
        begin
            status = ST_MISSING;
        end
        else if (unsupp)
        begin
            status = ST_UNSUPP;
        end
        else if (head.pos < min_last)
        begin
            status = ST_MISSING;
        end
        else if (is_req && head.terms != TERMS_TWO)
        begin
            status = ST_NOTERM;
        end
        else if (head.opcode == OP_ERROR && head.terms == TERMS_NONE)
        begin
            status = ST_NOTERM;
        end
        else
        begin
            status = ST_OK;
        end

        res_next.echo_byte    = head.pkt_byte;
        res_next.field_tag    = head.tag;
        res_next.packet_done  = head.last;
        res_next.parse_status = ST_OK;
        res_next.opcode_value = '0;
        res_next.number_value = '0;
        if (head.last)
        begin
            res_next.parse_status = status;
            if (head.pos != POS_OP_HI)
            begin
                res_next.opcode_value = head.opcode;
                if (is_num_op && head.pos >= POS_NUM_LO)
                begin
                    res_next.number_value = head.number;
                end
            end
        end

        res_valid_next = load ? head_valid : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> sv/tftp_packet_parser.sv
// ----------------------------------------------------------------------------
// tftp_packet_parser
// TFTP (RFC 1350 opcodes) packet parser, one byte per transfer, each byte
// echoed with its field tag; status, opcode and number on the final byte.
// ----------------------------------------------------------------------------
//   channel | signals                      | dir | payload
//   --------+------------------------------+-----+---------------------------
//   pkt     | pkt_valid, pkt_ready, pkt    | in  | packet_byte, is_last
//   res     | res_valid, res_ready, res    | out | echo, tag, done, status,
//           |                              |     | opcode, number
//
// One byte per cycle sustained while res is ready; a byte's result passes from
// the classifier into the queue on its transfer edge, then from the status
// stage into the output register, from which it is offered on res.
// Classifier next state is combinational per byte, so bytes follow each
// other with no gap. Reset clears position, opcode, number and terminator
// count and empties the queue. A stall on res fills the queue; pkt_ready drops
// only when it holds QUEUE_DEPTH entries.
// ----------------------------------------------------------------------------
module tftp_packet_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    output logic                pkt_ready,
    input  tpp_pkg::tpp_in_t    pkt,
    output logic                res_valid,
    input  logic                res_ready,
    output tpp_pkg::tpp_out_t   res
);
    import tpp_pkg::*;

    tpp_work_t  work;
    tpp_work_t  head;
    logic       take;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;

    assign pkt_ready = !q_full;
    assign take      = pkt_valid && pkt_ready;

    tpp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .pkt   (pkt),
        .work  (work)
    );

    tpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (take),
        .push_data  (work),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (head)
    );

    tpp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (head),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // summary fields are zero except on the final byte
    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.packet_done) |->
            (res.parse_status == ST_OK && res.opcode_value == 16'd0
             && res.number_value == 16'd0))
        else $error("summary fields set on a non-final byte");

    // a queued byte moves to a free output register on the next edge
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && (!res_valid || res_ready)) |=> res_valid)
        else $error("queued byte not moved to output");

    // input held off only while the queue holds bytes
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !pkt_ready |-> q_valid)
        else $error("input stalled with empty queue");

    // a packet that ends in its opcode field with a zero opcode value never reports ok
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.packet_done && res.opcode_value == 16'd0
         && res.field_tag == TAG_OPCODE) |-> (res.parse_status != ST_OK))
        else $error("short packet reported ok");

endmodule

>>> test/tb_tftp_packet_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tftp_packet_parser
// Self-checking bench for the TFTP packet parser. A short table of hand-built
// packets covers the edge cases. Random packets follow: mostly well-formed,
// some cut short and some plain noise. Every transfer on res is checked,
// field by field, against a byte-level model of the parser or a fixed
// table value. Both sides idle and stall in bursts.
// ----------------------------------------------------------------------------
module tb_tftp_packet_parser;
    import tpp_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          TOTAL_ITEMS  = 1950;
    localparam int          CALM_ITEMS   = 1700;
    localparam int          LONG_HOLD    = 150;
    localparam int          TAIL_CYCLES  = 8;
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    // lowest last-byte position at which each kind of packet is long enough
    localparam logic [2:0] MIN_POS_REQ  = 3'd5;
    localparam logic [2:0] MIN_POS_DATA = 3'd3;
    localparam logic [2:0] MIN_POS_ERR  = 3'd4;
    localparam logic [2:0] MIN_POS_NONE = 3'd0;

    typedef struct {
        tpp_in_t  stim;
        bit       known;
        tpp_out_t want;
    } directed_row_t;

    typedef struct {
        bit       known;
        tpp_out_t value;
    } result_mark_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     pkt_valid;
    logic     pkt_ready;
    tpp_in_t  pkt;
    logic     res_valid;
    logic     res_ready;
    tpp_out_t res;

    // parser state as the model sees it
    logic [2:0]  pos_q;
    logic [15:0] op_q;
    logic [15:0] num_q;
    logic [1:0]  terms_q;

    tpp_out_t      expected_results[$];
    result_mark_t  fixed_result_q[$];
    directed_row_t directed_rows[$];
    logic [7:0]    pkt_bytes[$];

    int  fail_count   = 0;
    int  sent_count   = 0;
    int  packets_seen = 0;
    int  status_seen[4];
    bit  calm         = 1'b0;
    bit  hold_pending = 1'b0;

    tftp_packet_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte model: tag for this byte, and the packet summary on the last one
    // ------------------------------------------------------------------
    task automatic classify_byte(input tpp_in_t b, output tpp_out_t r);
        logic [2:0] min_pos;
        r             = '0;
        r.echo_byte   = b.packet_byte;
        r.packet_done = b.is_last;
        r.field_tag   = TAG_TRAIL;
        if (pos_q == POS_OP_HI)
        begin
            op_q        = {b.packet_byte, 8'h00};
            r.field_tag = TAG_OPCODE;
        end
        else if (pos_q == POS_OP_LO)
        begin
            op_q[7:0]   = b.packet_byte;
            r.field_tag = TAG_OPCODE;
        end
        else
        begin
            if (pos_q == POS_NUM_HI)
                num_q = {b.packet_byte, 8'h00};
            else if (pos_q == POS_NUM_LO)
                num_q[7:0] = b.packet_byte;
            case (op_q)
                OP_RRQ, OP_WRQ:
                begin
                    if (terms_q == TERMS_NONE)
                    begin
                        r.field_tag = (b.packet_byte == 8'h00) ? TAG_NAME_END : TAG_FILENAME;
                        if (b.packet_byte == 8'h00)
                            terms_q = TERMS_ONE;
                    end
                    else if (terms_q == TERMS_ONE)
                    begin
                        r.field_tag = (b.packet_byte == 8'h00) ? TAG_MODE_END : TAG_MODE;
                        if (b.packet_byte == 8'h00)
                            terms_q = TERMS_TWO;
                    end
                end
                OP_DATA:
                    r.field_tag = (pos_q <= POS_NUM_LO) ? TAG_BLOCK : TAG_PAYLOAD;
                OP_ACK:
                    r.field_tag = (pos_q <= POS_NUM_LO) ? TAG_BLOCK : TAG_TRAIL;
                OP_ERROR:
                begin
                    if (pos_q <= POS_NUM_LO)
                        r.field_tag = TAG_CODE;
                    else if (terms_q == TERMS_NONE)
                    begin
                        r.field_tag = (b.packet_byte == 8'h00) ? TAG_MSG_END : TAG_MESSAGE;
                        if (b.packet_byte == 8'h00)
                            terms_q = TERMS_ONE;
                    end
                end
                default:
                    r.field_tag = TAG_TRAIL;
            endcase
        end

        if (b.is_last)
        begin
            if (pos_q == POS_OP_HI)
                r.parse_status = ST_MISSING;
            else
            begin
                r.opcode_value = op_q;
                case (op_q)
                    OP_RRQ, OP_WRQ: min_pos = MIN_POS_REQ;
                    OP_DATA, OP_ACK: min_pos = MIN_POS_DATA;
                    OP_ERROR: min_pos = MIN_POS_ERR;
                    default: min_pos = MIN_POS_NONE;
                endcase
                if (op_q < OP_RRQ || op_q > OP_ERROR)
                    r.parse_status = ST_UNSUPP;
                else if (pos_q < min_pos)
                    r.parse_status = ST_MISSING;
                else if ((op_q == OP_RRQ || op_q == OP_WRQ) && terms_q < TERMS_TWO)
                    r.parse_status = ST_NOTERM;
                else if (op_q == OP_ERROR && terms_q < TERMS_ONE)
                    r.parse_status = ST_NOTERM;
                else
                    r.parse_status = ST_OK;
                if ((op_q == OP_DATA || op_q == OP_ACK || op_q == OP_ERROR)
                    && pos_q >= POS_NUM_LO)
                    r.number_value = num_q;
            end
            pos_q   = POS_OP_HI;
            op_q    = '0;
            num_q   = '0;
            terms_q = TERMS_NONE;
        end
        else if (pos_q != POS_MAX)
            pos_q = pos_q + 3'd1;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on each pkt transfer, check on each res transfer
    // ------------------------------------------------------------------
    initial
    begin
        pos_q   = POS_OP_HI;
        op_q    = '0;
        num_q   = '0;
        terms_q = TERMS_NONE;
        foreach (status_seen[i])
            status_seen[i] = 0;
    end

    always @(posedge clk)
    begin : monitor
        tpp_out_t     predicted;
        tpp_out_t     want;
        result_mark_t mark;
        if (pkt_valid && pkt_ready)
        begin
            classify_byte(pkt, predicted);
            mark = fixed_result_q.pop_front();
            expected_results.push_back(mark.known ? mark.value : predicted);
        end
        if (res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("res transfer with nothing outstanding: echo_byte 0x%0h",
                       res.echo_byte);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("echo_byte", 16'(want.echo_byte), 16'(res.echo_byte));
                check_field("field_tag", 16'(want.field_tag), 16'(res.field_tag));
                check_field("packet_done", 16'(want.packet_done), 16'(res.packet_done));
                check_field("parse_status", 16'(want.parse_status), 16'(res.parse_status));
                check_field("opcode_value", want.opcode_value, res.opcode_value);
                check_field("number_value", want.number_value, res.number_value);
            end
            if (res.packet_done === 1'b1)
            begin
                packets_seen++;
                status_seen[res.parse_status]++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        res_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Packet side
    // ------------------------------------------------------------------
    // entered and left at a falling edge; valid stays up between back-to-back calls
    task automatic send_byte(input tpp_in_t b, input bit known, input tpp_out_t want);
        result_mark_t mark;
        int           gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            pkt_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mark.known = known;
        mark.value = want;
        fixed_result_q.push_back(mark);
        pkt_valid <= 1'b1;
        pkt       <= b;
        @(posedge clk);
        while (!pkt_ready)
            @(posedge clk);
        sent_count++;
        if (sent_count >= CALM_ITEMS)
            calm = 1'b1;
        @(negedge clk);
    endtask

    task automatic add_row(input logic [7:0] b, input logic last, input bit known,
                           input tpp_out_t want);
        directed_row_t r;
        r.stim.packet_byte = b;
        r.stim.is_last     = last;
        r.known            = known;
        r.want             = want;
        directed_rows.push_back(r);
    endtask

    task automatic add_text(input int n);
        repeat (n) pkt_bytes.push_back(8'($urandom_range(1, 255)));
    endtask

    task automatic add_noise(input int n);
        repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_packet();
        int          kind;
        int          n;
        logic [15:0] op;
        pkt_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 85)
        begin
            // noise, often with a zero high opcode byte
            add_noise($urandom_range(1, 9));
            if (pkt_bytes.size() > 1 && $urandom_range(0, 1))
                pkt_bytes[0] = 8'h00;
            return;
        end
        op = 16'($urandom_range(OP_RRQ, OP_ERROR));
        pkt_bytes.push_back(op[15:8]);
        pkt_bytes.push_back(op[7:0]);
        case (op)
            OP_RRQ, OP_WRQ:
            begin
                add_text($urandom_range(0, 4));
                pkt_bytes.push_back(8'h00);
                add_text($urandom_range(0, 4));
                pkt_bytes.push_back(8'h00);
                add_noise($urandom_range(0, 2));
            end
            OP_DATA:
            begin
                add_noise(2);
                add_noise(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(0, 12));
            end
            OP_ACK:
            begin
                add_noise(2);
                add_noise($urandom_range(0, 2));
            end
            default:
            begin
                add_noise(2);
                add_text($urandom_range(0, 5));
                pkt_bytes.push_back(8'h00);
                add_noise($urandom_range(0, 2));
            end
        endcase
        // truncated packets
        if (kind >= 65)
        begin
            n = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > n)
                void'(pkt_bytes.pop_back());
        end
    endtask

    initial
    begin : sender
        tpp_in_t b;
        int      packet_count;
        rst_n     = 1'b0;
        pkt_valid = 1'b0;
        pkt       = '0;
        packet_count = 0;

        // single-byte packets, then a two-byte packet with the unsupported opcode at the extreme
        add_row(8'hFF, 1'b1, 1'b1, {8'hFF, TAG_OPCODE, 1'b1, ST_MISSING, 16'h0000, 16'h0000});
        add_row(8'h00, 1'b1, 1'b1, {8'h00, TAG_OPCODE, 1'b1, ST_MISSING, 16'h0000, 16'h0000});
        add_row(8'hFF, 1'b0, 1'b1, {8'hFF, TAG_OPCODE, 1'b0, ST_OK, 16'h0000, 16'h0000});
        add_row(8'hFF, 1'b1, 1'b1, {8'hFF, TAG_OPCODE, 1'b1, ST_UNSUPP, 16'hFFFF, 16'h0000});
        // write request with a trailing byte after the mode zero
        add_row(OP_WRQ[15:8], 1'b0, 1'b0, '0);
        add_row(OP_WRQ[7:0], 1'b0, 1'b0, '0);
        add_row(8'h41, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h6F, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h7A, 1'b1, 1'b0, '0);
        // data, block number at its maximum
        add_row(OP_DATA[15:8], 1'b0, 1'b0, '0);
        add_row(OP_DATA[7:0], 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'h80, 1'b1, 1'b0, '0);
        // ack cut short
        add_row(OP_ACK[15:8], 1'b0, 1'b0, '0);
        add_row(OP_ACK[7:0], 1'b0, 1'b0, '0);
        add_row(8'h12, 1'b1, 1'b0, '0);
        // error whose message never ends
        add_row(OP_ERROR[15:8], 1'b0, 1'b0, '0);
        add_row(OP_ERROR[7:0], 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h07, 1'b0, 1'b0, '0);
        add_row(8'h65, 1'b1, 1'b1, {8'h65, TAG_MESSAGE, 1'b1, ST_NOTERM, OP_ERROR, 16'h0007});

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].want);

        // let the parser drain completely before the random part
        pkt_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);

        while (sent_count < TOTAL_ITEMS)
        begin
            build_packet();
            packet_count++;
            // one long hold on res while packets keep coming, to back up the queue
            if (packet_count == 10)
                hold_pending = 1'b1;
            foreach (pkt_bytes[i])
            begin
                b.packet_byte = pkt_bytes[i];
                b.is_last     = (i == pkt_bytes.size() - 1);
                send_byte(b, 1'b0, '0);
            end
        end
        pkt_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d bytes in %0d packets parsed and checked", sent_count, packets_seen);
        $display("final status: ok %0d, data missing %0d, no terminator %0d, unsupported %0d",
                 status_seen[ST_OK], status_seen[ST_MISSING], status_seen[ST_NOTERM],
                 status_seen[ST_UNSUPP]);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
